// ----- design/arp_pkg.sv -----
// ----------------------------------------------------------------------------
// arp_pkg
// Shared types and constants for the axis reduction engine.
// ----------------------------------------------------------------------------
package arp_pkg;

    localparam int ACC_W        = 48;
    localparam int SAMPLE_IN_W  = 32;
    localparam int INDEX_OUT_W  = 16;
    localparam int LANE_OUT_W   = 8;
    localparam int OUT_DATA_W   = ACC_W + INDEX_OUT_W + LANE_OUT_W;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 17;

    localparam int DEF_MAX_INNER    = 256;
    localparam int DEF_MAX_LEN      = 65536;
    localparam int DEF_SAMPLE_WIDTH = 32;

    typedef enum logic [2:0] {
        OP_SUM    = 3'd0,
        OP_MEAN   = 3'd1,
        OP_MAX    = 3'd2,
        OP_MIN    = 3'd3,
        OP_ARGMAX = 3'd4,
        OP_ARGMIN = 3'd5
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OP    = 2'd0,
        CFG_LEN   = 2'd1,
        CFG_INNER = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        DIV_IDLE = 2'd0,
        DIV_BUSY = 2'd1,
        DIV_DONE = 2'd2
    } t_div_state;

    typedef struct packed {
        logic                    start;
        logic signed [ACC_W-1:0] dividend;
    } t_div_req;

    typedef struct packed {
        logic                    idle;
        logic                    valid;
        logic signed [ACC_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ----- design/arp_ram.sv -----
// ----------------------------------------------------------------------------
// arp_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module arp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/arp_div.sv -----
// ----------------------------------------------------------------------------
// arp_div
// Bit-serial signed by unsigned divider, truncating toward zero.
// ----------------------------------------------------------------------------
module arp_div
    import arp_pkg::*;
#(
    parameter int DIV_W = 17
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    input  logic [DIV_W-1:0] i_divisor,
    input  logic             i_take,
    output t_div_rsp         o_rsp
);

    localparam int CNT_W = $clog2(ACC_W);

    t_div_state r_state, n_state;
    logic [ACC_W-1:0] r_quo;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg;

    logic [DIV_W:0]   w_shift;
    logic [DIV_W:0]   w_diff;
    logic             w_step;
    logic             w_last;

    assign w_shift = {r_rem, r_quo[ACC_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};
    assign w_last  = (r_cnt == CNT_W'(ACC_W - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            DIV_IDLE: if (i_req.start) n_state = DIV_BUSY;
            DIV_BUSY: if (w_last) n_state = DIV_DONE;
            DIV_DONE: if (i_take) n_state = DIV_IDLE;
            default:  n_state = DIV_IDLE;
        endcase
    end

    always_comb begin
        o_rsp.idle     = 1'b0;
        o_rsp.valid    = 1'b0;
        o_rsp.quotient = r_neg ? -$signed(r_quo) : $signed(r_quo);
        w_step         = 1'b0;
        case (r_state)
            DIV_IDLE: o_rsp.idle  = 1'b1;
            DIV_BUSY: w_step      = 1'b1;
            DIV_DONE: o_rsp.valid = 1'b1;
            default:  o_rsp.idle  = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DIV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rsp.idle && i_req.start) begin
            r_neg <= i_req.dividend[ACC_W-1];
            r_quo <= i_req.dividend[ACC_W-1] ? ACC_W'(-i_req.dividend)
                                              : ACC_W'(i_req.dividend);
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_cnt <= '0;
        end else if (w_step) begin
            r_cnt <= r_cnt + 1'b1;
            if (!w_diff[DIV_W]) begin
                r_rem <= w_diff[DIV_W-1:0];
                r_quo <= {r_quo[ACC_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[DIV_W-1:0];
                r_quo <= {r_quo[ACC_W-2:0], 1'b0};
            end
        end
    end

endmodule

// ----- design/axis_reduction_engine_top.sv -----
// ----------------------------------------------------------------------------
// axis_reduction_engine_top
// Streaming sum / mean / max / min / argmax / argmin along one tensor axis.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries Q16.16 samples in memory order: per outer slice,
//   reduce_len rows of inner_count lanes. Each lane's accumulator and best
//   row live in one RAM, read on accept and written back from the RMW stage;
//   a bypass register covers back-to-back requests to the same lane.
//   m_axis carries one result per sample of the last row; tlast marks the
//   last lane of a slice. cfg writes op (0), length (1), lanes (2) while
//   idle; each write to these restarts at row 0, lane 0.
//   Throughput: one sample per cycle, set by the single RAM read/write
//   pass, unless an emitting sample waits on the divider or output. Accept
//   feeds the RMW stage, then the output register. Mean results pass a
//   48-step serial divider; a second waits on it and holds off s_axis.
//   Reset: registers return to sum, length 1, one lane; no RAM clear pass.
//   When m_axis stalls, the output register holds; s_axis keeps accepting
//   samples until a result can not be placed.
// ----------------------------------------------------------------------------
module axis_reduction_engine_top
    import arp_pkg::*;
#(
    parameter int MAX_INNER    = DEF_MAX_INNER,
    parameter int MAX_LEN      = DEF_MAX_LEN,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // [31:0] sample_value
    input  logic [SAMPLE_IN_W-1:0] i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [47:0] result_value, [63:48] result_index, [71:64] lane_number
    output logic [OUT_DATA_W-1:0]  o_m_axis_tdata,
    output logic                   o_m_axis_tlast,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int LANE_W = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
    localparam int ROW_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int MEM_W  = ACC_W + ROW_W;
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // configuration
    t_op               r_op;
    logic [LEN_W-1:0]  r_len;
    logic [ROW_W-1:0]  r_len_last;
    logic [LANE_W-1:0] r_inner_last;
    logic [31:0]       w_len_eff;
    logic [31:0]       w_inner_eff;
    logic              w_cfg_fire;

    // position
    logic [LANE_W-1:0] r_lane;
    logic [ROW_W-1:0]  r_row;

    // RMW stage
    logic                    r_s1_valid;
    logic signed [ACC_W-1:0] r_s1_x;
    logic [LANE_W-1:0]       r_s1_lane;
    logic [ROW_W-1:0]        r_s1_row;
    logic                    r_s1_byp;
    logic signed [ACC_W-1:0] r_byp_acc;
    logic [ROW_W-1:0]        r_byp_best;

    // output register
    logic                    r_out_valid;
    logic signed [ACC_W-1:0] r_out_value;
    logic [ROW_W-1:0]        r_out_index;
    logic [LANE_W-1:0]       r_out_lane;
    logic                    r_out_last;

    // divider tags
    logic [LANE_W-1:0] r_div_lane;
    logic              r_div_last;

    logic signed [SAMPLE_WIDTH-1:0] w_smp;
    logic signed [ACC_W-1:0]        w_x;
    logic                           w_in_fire;
    logic [MEM_W-1:0]               w_rdata;
    logic signed [ACC_W-1:0]        w_old_acc;
    logic [ROW_W-1:0]               w_old_best;
    logic signed [ACC_W:0]          w_sum;
    logic signed [ACC_W-1:0]        w_sum_sat;
    logic signed [ACC_W-1:0]        w_new_acc;
    logic [ROW_W-1:0]               w_new_best;
    logic                           w_emit;
    logic                           w_is_mean;
    logic                           w_is_arg;
    logic                           w_out_free;
    logic                           w_s1_go;
    logic                           w_s1_direct;
    logic                           w_div_take;
    t_div_req                       w_div_req;
    t_div_rsp                       w_div_rsp;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_fire  = i_cfg_valid && o_cfg_ready;

    always_comb begin
        if (i_cfg_data == '0) begin
            w_len_eff = 32'd1;
        end else if (32'(i_cfg_data) > 32'(MAX_LEN)) begin
            w_len_eff = 32'(MAX_LEN);
        end else begin
            w_len_eff = 32'(i_cfg_data);
        end
        if (i_cfg_data[8:0] == '0) begin
            w_inner_eff = 32'd1;
        end else if (32'(i_cfg_data[8:0]) > 32'(MAX_INNER)) begin
            w_inner_eff = 32'(MAX_INNER);
        end else begin
            w_inner_eff = 32'(i_cfg_data[8:0]);
        end
    end

    assign w_smp     = i_s_axis_tdata[SAMPLE_WIDTH-1:0];
    assign w_x       = ACC_W'(w_smp);
    assign w_in_fire = i_s_axis_tvalid && o_s_axis_tready;

    // RMW combine
    assign w_old_acc  = r_s1_byp ? r_byp_acc  : $signed(w_rdata[ACC_W-1:0]);
    assign w_old_best = r_s1_byp ? r_byp_best : w_rdata[MEM_W-1:ACC_W];
    assign w_sum      = {r_s1_x[ACC_W-1], r_s1_x} + {w_old_acc[ACC_W-1], w_old_acc};

    always_comb begin
        if (w_sum[ACC_W] != w_sum[ACC_W-1]) begin
            w_sum_sat = w_sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            w_sum_sat = w_sum[ACC_W-1:0];
        end
    end

    always_comb begin
        w_new_acc  = w_old_acc;
        w_new_best = w_old_best;
        if (r_s1_row == '0) begin
            w_new_acc  = r_s1_x;
            w_new_best = '0;
        end else begin
            case (r_op)
                OP_SUM, OP_MEAN: w_new_acc = w_sum_sat;
                OP_MAX, OP_ARGMAX: begin
                    if (r_s1_x > w_old_acc) begin
                        w_new_acc  = r_s1_x;
                        w_new_best = r_s1_row;
                    end
                end
                OP_MIN, OP_ARGMIN: begin
                    if (r_s1_x < w_old_acc) begin
                        w_new_acc  = r_s1_x;
                        w_new_best = r_s1_row;
                    end
                end
                default: w_new_acc = w_sum_sat;
            endcase
        end
    end

    assign w_emit      = (r_s1_row == r_len_last);
    assign w_is_mean   = (r_op == OP_MEAN);
    assign w_is_arg    = (r_op == OP_ARGMAX) || (r_op == OP_ARGMIN);
    assign w_out_free  = !r_out_valid || i_m_axis_tready;
    assign w_s1_direct = r_s1_valid && w_emit && !w_is_mean;

    always_comb begin
        if (!w_emit) begin
            w_s1_go = r_s1_valid;
        end else if (w_is_mean) begin
            w_s1_go = r_s1_valid && w_div_rsp.idle;
        end else begin
            w_s1_go = r_s1_valid && w_div_rsp.idle && w_out_free;
        end
    end

    assign o_s_axis_tready = !r_s1_valid || w_s1_go;

    assign w_div_req.start    = w_s1_go && w_emit && w_is_mean;
    assign w_div_req.dividend = w_new_acc;
    assign w_div_take         = w_div_rsp.valid && w_out_free;

    arp_ram #(
        .WIDTH (MEM_W),
        .DEPTH (MAX_INNER)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_s1_go),
        .i_waddr (r_s1_lane),
        .i_wdata ({w_new_best, w_new_acc}),
        .i_re    (w_in_fire),
        .i_raddr (r_lane),
        .o_rdata (w_rdata)
    );

    arp_div #(
        .DIV_W (LEN_W)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_div_req),
        .i_divisor (r_len),
        .i_take    (w_div_take),
        .o_rsp     (w_div_rsp)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op         <= OP_SUM;
            r_len        <= LEN_W'(1);
            r_len_last   <= '0;
            r_inner_last <= '0;
            r_lane       <= '0;
            r_row        <= '0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_cfg_fire) begin
                case (i_cfg_index)
                    CFG_OP: begin
                        r_op   <= (i_cfg_data[2:0] > 3'(OP_ARGMIN)) ? OP_SUM
                                                                    : t_op'(i_cfg_data[2:0]);
                        r_lane <= '0;
                        r_row  <= '0;
                    end
                    CFG_LEN: begin
                        r_len      <= LEN_W'(w_len_eff);
                        r_len_last <= ROW_W'(w_len_eff - 32'd1);
                        r_lane     <= '0;
                        r_row      <= '0;
                    end
                    CFG_INNER: begin
                        r_inner_last <= LANE_W'(w_inner_eff - 32'd1);
                        r_lane       <= '0;
                        r_row        <= '0;
                    end
                    default: r_lane <= r_lane;
                endcase
            end else if (w_in_fire) begin
                if (r_lane == r_inner_last) begin
                    r_lane <= '0;
                    r_row  <= (r_row == r_len_last) ? '0 : r_row + 1'b1;
                end else begin
                    r_lane <= r_lane + 1'b1;
                end
            end

            if (w_in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_go) begin
                r_s1_valid <= 1'b0;
            end

            if (w_div_take || (w_s1_go && w_s1_direct)) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1_x     <= w_x;
            r_s1_lane  <= r_lane;
            r_s1_row   <= r_row;
            r_s1_byp   <= w_s1_go && (r_s1_lane == r_lane);
            r_byp_acc  <= w_new_acc;
            r_byp_best <= w_new_best;
        end

        if (w_div_req.start) begin
            r_div_lane <= r_s1_lane;
            r_div_last <= (r_s1_lane == r_inner_last);
        end

        if (w_div_take) begin
            r_out_value <= w_div_rsp.quotient;
            r_out_index <= '0;
            r_out_lane  <= r_div_lane;
            r_out_last  <= r_div_last;
        end else if (w_s1_go && w_s1_direct) begin
            r_out_value <= w_new_acc;
            r_out_index <= w_is_arg ? w_new_best : '0;
            r_out_lane  <= r_s1_lane;
            r_out_last  <= (r_s1_lane == r_inner_last);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {LANE_OUT_W'(r_out_lane), INDEX_OUT_W'(r_out_index),
                              r_out_value};

endmodule

// ----- design/arp_chk.sv -----
// ----------------------------------------------------------------------------
// arp_chk
// Port-level checks for the axis reduction engine, bound to the top level.
// ----------------------------------------------------------------------------
module arp_chk
    import arp_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_axis_tvalid,
    input logic                   o_s_axis_tready,
    input logic [SAMPLE_IN_W-1:0] i_s_axis_tdata,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_DATA_W-1:0]  o_m_axis_tdata,
    input logic                   o_m_axis_tlast,
    input logic                   i_cfg_valid,
    input logic                   o_cfg_ready,
    input logic [CFG_IDX_W-1:0]   i_cfg_index,
    input logic [CFG_DATA_W-1:0]  i_cfg_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("result changed while stalled");

    a_no_out_after_rst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_m_axis_tvalid)
        else $error("result present right after reset");

    a_ready_after_rst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> o_s_axis_tready)
        else $error("input not ready after reset");

    a_no_out_from_nothing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n, 2) && $past(!(i_s_axis_tvalid && o_s_axis_tready))
            |-> !o_m_axis_tvalid)
        else $error("result without a request");

endmodule

bind axis_reduction_engine_top arp_chk u_arp_chk (.*);

// ----- bench/axis_reduction_engine_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// axis_reduction_engine_top_tb
// Self-checking bench for the axis reduction engine. A scoreboard tracks the
// per-lane accumulators, best rows and stream position. For every accepted
// request of a last row it predicts the result it should produce, and each
// result beat is checked against the oldest prediction. Directed slices come
// first, then short runs on a clamped and a full-length axis, a back-pressure
// run, and randomly configured phases. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module axis_reduction_engine_top_tb;
    import arp_pkg::*;

    localparam int     CLK_HALF        = 4;
    localparam int     SETTLE_CYCLES   = 64;
    localparam int     HOLD_OFF_CYCLES = 300;
    localparam int     QUIET_LIMIT     = 4000;
    localparam int     RANDOM_PHASES   = 6;
    localparam int     REPORT_LIMIT    = 10;
    localparam int     LONG_AXIS_RUN   = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam longint ACC_HI = 64'sd140737488355327;
    localparam longint ACC_LO = -ACC_HI - 1;

    typedef struct packed {
        logic [ACC_W-1:0]       value;
        logic [INDEX_OUT_W-1:0] row;
        logic [LANE_OUT_W-1:0]  lane;
        logic                   last;
    } t_lane_result;

    class lane_reduction_scoreboard;
        logic [2:0]             op_reg;
        logic [CFG_DATA_W-1:0]  len_reg;
        logic [8:0]             inner_reg;
        longint                 lane_acc [DEF_MAX_INNER];
        logic [INDEX_OUT_W-1:0] lane_best [DEF_MAX_INNER];
        int                     row_pos;
        int                     lane_pos;
        t_lane_result           expected_results[$];
        int                     mismatch_count;

        function new();
            op_reg         = OP_SUM;
            len_reg        = 17'd1;
            inner_reg      = 9'd1;
            row_pos        = 0;
            lane_pos       = 0;
            mismatch_count = 0;
            foreach (lane_acc[i]) begin
                lane_acc[i]  = 0;
                lane_best[i] = '0;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_OP:    op_reg = val[2:0];
                CFG_LEN:   len_reg = val;
                CFG_INNER: inner_reg = val[8:0];
                default:   return;
            endcase
            row_pos  = 0;
            lane_pos = 0;
        endfunction

        // one accepted sample: update the lane, queue the lane result on the last row
        function void note_sample(logic [SAMPLE_IN_W-1:0] raw);
            int           len_eff;
            int           inner_eff;
            int           lane;
            int           row;
            t_op          op;
            longint       x;
            longint       acc;
            t_lane_result r;
            len_eff   = (len_reg == 0) ? 1 :
                        (len_reg > DEF_MAX_LEN) ? DEF_MAX_LEN : int'(len_reg);
            inner_eff = (inner_reg == 0) ? 1 :
                        (inner_reg > DEF_MAX_INNER) ? DEF_MAX_INNER : int'(inner_reg);
            op        = (op_reg > OP_ARGMIN) ? OP_SUM : t_op'(op_reg);
            lane      = (lane_pos >= inner_eff) ? 0 : lane_pos;
            row       = (row_pos >= len_eff) ? 0 : row_pos;
            x         = longint'($signed(raw));

            if (row == 0) begin
                lane_acc[lane]  = x;
                lane_best[lane] = '0;
            end else begin
                case (op)
                    OP_SUM, OP_MEAN: begin
                        acc = lane_acc[lane] + x;
                        if (acc > ACC_HI) acc = ACC_HI;
                        if (acc < ACC_LO) acc = ACC_LO;
                        lane_acc[lane] = acc;
                    end
                    OP_MAX, OP_ARGMAX: begin
                        if (x > lane_acc[lane]) begin
                            lane_acc[lane]  = x;
                            lane_best[lane] = row[INDEX_OUT_W-1:0];
                        end
                    end
                    default: begin
                        if (x < lane_acc[lane]) begin
                            lane_acc[lane]  = x;
                            lane_best[lane] = row[INDEX_OUT_W-1:0];
                        end
                    end
                endcase
            end

            if (row == len_eff - 1) begin
                acc = lane_acc[lane];
                if (op == OP_MEAN) acc = acc / len_eff;
                r.value = acc[ACC_W-1:0];
                r.row   = (op == OP_ARGMAX || op == OP_ARGMIN) ? lane_best[lane] : '0;
                r.lane  = lane[LANE_OUT_W-1:0];
                r.last  = (lane == inner_eff - 1);
                expected_results.push_back(r);
            end

            lane++;
            if (lane >= inner_eff) begin
                lane = 0;
                row++;
                if (row >= len_eff) row = 0;
            end
            lane_pos = lane;
            row_pos  = row;
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data, logic last);
            t_lane_result want;
            t_lane_result got;
            got.value = data[ACC_W-1:0];
            got.row   = data[ACC_W +: INDEX_OUT_W];
            got.lane  = data[ACC_W+INDEX_OUT_W +: LANE_OUT_W];
            got.last  = last;
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result: value %h index %0d lane %0d last %b",
                             got.value, got.row, got.lane, got.last);
                return;
            end
            want = expected_results.pop_front();
            if (got.value !== want.value || got.row !== want.row ||
                got.lane !== want.lane || got.last !== want.last) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("result mismatch: exp value %h index %0d lane %0d last %b, %s",
                             want.value, want.row, want.lane, want.last,
                             $sformatf("got value %h index %0d lane %0d last %b",
                                       got.value, got.row, got.lane, got.last));
            end
        endfunction
    endclass

    logic                   clk        = 1'b0;
    logic                   rst_n      = 1'b0;
    logic                   s_tvalid   = 1'b0;
    logic [SAMPLE_IN_W-1:0] s_tdata    = '0;
    logic                   m_tready   = 1'b0;
    logic                   cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index  = '0;
    logic [CFG_DATA_W-1:0]  cfg_data   = '0;
    logic                   s_tready;
    logic                   m_tvalid;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   m_tlast;
    logic                   cfg_ready;

    bit s_gap_on        = 1'b1;
    bit m_gap_on        = 1'b1;
    int hold_off_asked  = 0;
    int hold_off_served = 0;
    int hold_left       = 0;
    int rx_stall        = 0;
    int quiet_cycles    = 0;

    lane_reduction_scoreboard sb;

    axis_reduction_engine_top DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    function automatic int gap_length(bit enabled);
        int pick;
        if (!enabled) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 70) return 0;
        if (pick < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [SAMPLE_IN_W-1:0] pick_sample();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 8) - 4;
            1: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    // result sink: random stalls plus an occasional long hold-off
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_off_served != hold_off_asked) begin
            hold_off_served <= hold_off_asked;
            hold_left = HOLD_OFF_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (rx_stall == 0) rx_stall = gap_length(m_gap_on);
            if (rx_stall > 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_sample(logic [SAMPLE_IN_W-1:0] sample);
        int gap;
        gap = gap_length(s_gap_on);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sample;
        do @(posedge clk); while (!s_tready);
        sb.note_sample(sample);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.write_register(idx, val);
    endtask

    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    // idle point: results drained and any mean divide in flight finished
    task automatic drain_results();
        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin : stimulus
        int count;
        int pick;
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: sum, one row, one lane
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);

        // argmax, 3 rows x 2 lanes; lane 0 ties on every row
        drain_results();
        write_register(CFG_OP, CFG_DATA_W'(OP_ARGMAX));
        write_register(CFG_LEN, 17'd3);
        write_register(CFG_INNER, 17'd2);
        cfg_valid <= 1'b0;
        send_sample(32'd5);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'd5);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'd5);
        send_sample(32'h8000_0000);

        // argmin tie at the most negative sample
        drain_results();
        write_register(CFG_OP, CFG_DATA_W'(OP_ARGMIN));
        write_register(CFG_LEN, 17'd2);
        write_register(CFG_INNER, 17'd1);
        cfg_valid <= 1'b0;
        send_sample(32'h8000_0000);
        send_sample(32'h8000_0000);

        // mean of -1,-1,0 truncates toward zero
        drain_results();
        write_register(CFG_OP, CFG_DATA_W'(OP_MEAN));
        write_register(CFG_LEN, 17'd3);
        cfg_valid <= 1'b0;
        send_sample(32'hFFFF_FFFF);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'd0);

        // unknown op code, zero length and zero lanes
        drain_results();
        write_register(CFG_OP, 17'd7);
        write_register(CFG_LEN, 17'd0);
        write_register(CFG_INNER, 17'd0);
        cfg_valid <= 1'b0;
        send_sample(32'hFFFF_FFFF);
        send_sample(32'd1);

        // spare index leaves the stream position alone; a real write restarts it
        drain_results();
        write_register(CFG_OP, CFG_DATA_W'(OP_MIN));
        write_register(CFG_LEN, 17'd2);
        write_register(CFG_INNER, 17'd2);
        cfg_valid <= 1'b0;
        send_sample(32'd3);
        drain_results();
        write_register(CFG_SPARE, 17'h1FFFF);
        cfg_valid <= 1'b0;
        send_sample(32'd2);
        send_sample(32'd1);
        send_sample(32'd4);
        send_sample(32'd9);
        drain_results();
        write_register(CFG_INNER, 17'd2);
        cfg_valid <= 1'b0;
        send_sample(32'd8);
        send_sample(32'd7);
        send_sample(32'd6);
        send_sample(32'd5);

        // length above max clamps; a short run on the long axis gives no result
        drain_results();
        s_gap_on = 1'b0;
        write_register(CFG_OP, CFG_DATA_W'(OP_ARGMAX));
        write_register(CFG_LEN, 17'h1FFFF);
        write_register(CFG_INNER, 17'd1);
        cfg_valid <= 1'b0;
        for (count = 0; count < LONG_AXIS_RUN; count++)
            send_sample($urandom_range(0, 1000));

        // unknown op code on a full-length axis, short run
        drain_results();
        write_register(CFG_OP, 17'd6);
        write_register(CFG_LEN, 17'h10000);
        cfg_valid <= 1'b0;
        for (count = 0; count < LONG_AXIS_RUN; count++)
            send_sample(32'h8000_0000);

        // 256 lanes, long sink hold-off while requests keep coming
        drain_results();
        m_gap_on <= 1'b1;
        write_register(CFG_OP, CFG_DATA_W'(OP_MAX));
        write_register(CFG_LEN, 17'd1);
        write_register(CFG_INNER, 17'h001FF);
        cfg_valid <= 1'b0;
        for (count = 0; count < 300; count++) begin
            if (count == 20) hold_off_asked <= hold_off_asked + 1;
            if (count == 150) pause_until_drained();
            send_sample(pick_sample());
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_results();
            s_gap_on = ($urandom_range(0, 3) != 0);
            m_gap_on <= ($urandom_range(0, 3) != 0);
            write_register(CFG_OP,
                           CFG_DATA_W'(($urandom() & 32'h1FFF8) | $urandom_range(0, 7)));
            pick = $urandom_range(0, 9);
            write_register(CFG_LEN, CFG_DATA_W'((pick == 0) ? 0 : $urandom_range(1, 6)));
            pick = $urandom_range(0, 9);
            write_register(CFG_INNER, CFG_DATA_W'(($urandom() & 32'h1FE00) |
                           ((pick == 0) ? 0 : (pick == 1) ? 256 : $urandom_range(1, 6))));
            cfg_valid <= 1'b0;
            pick = $urandom_range(0, 3);
            for (count = $urandom_range(25, 55); count > 0; count--) begin
                if (pick == 0 && count == 12) pause_until_drained();
                send_sample(pick_sample());
            end
        end

        drain_results();
        if (sb.mismatch_count == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/arp_pkg.sv
design/arp_ram.sv
design/arp_div.sv
design/axis_reduction_engine_top.sv
design/arp_chk.sv
bench/axis_reduction_engine_top_tb.sv
